// ===== src/ltp_pkg.sv =====
// ----------------------------------------------------------------------------
// ltp_pkg
// Shared types and constants for the light command TLV parser.
// ----------------------------------------------------------------------------
package ltp_pkg;

  localparam int NUM_PARAMS_DEFAULT = 15;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_PARAM_ONLY_CODE = 1'b0;
  localparam logic [7:0] PARAM_ONLY_CODE_RESET = 8'hFF;

  localparam logic [3:0] ID_PERIOD = 4'd6;
  localparam logic [3:0] ID_PHASE = 4'd8;

  localparam logic WRITE_PATTERN = 1'b0;
  localparam logic WRITE_PARAM = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ID   = 4'b0010,
    PH_VAL  = 4'b0100,
    PH_LOW  = 4'b1000
  } ltp_phase_t;

  typedef struct packed {
    logic        write_kind;
    logic [7:0]  pattern_code;
    logic        pattern_changed;
    logic [3:0]  param_index;
    logic [15:0] param_value;
  } ltp_result_t;

  function automatic logic is_pair(input logic [3:0] id);
    return (id == ID_PERIOD) || (id == ID_PHASE);
  endfunction

endpackage

// ===== src/ltp_if.sv =====
// ----------------------------------------------------------------------------
// ltp_if
// Valid/ready channels for command bytes and for parser write requests.
// ----------------------------------------------------------------------------
interface ltp_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output cmd_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input cmd_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface ltp_wr_if;
  logic        valid;
  logic        ready;
  logic        write_kind;
  logic [7:0]  pattern_code;
  logic        pattern_changed;
  logic [3:0]  param_index;
  logic [15:0] param_value;

  modport source (output valid, output write_kind, output pattern_code,
                  output pattern_changed, output param_index, output param_value,
                  input ready);
  modport sink (input valid, input write_kind, input pattern_code,
                input pattern_changed, input param_index, input param_value,
                output ready);
endinterface

// ===== src/ltp_apb_regs.sv =====
// ----------------------------------------------------------------------------
// ltp_apb_regs
// APB register file holding the parameter-only code.
// ----------------------------------------------------------------------------
module ltp_apb_regs
  import ltp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [7:0]            param_only_code
);

  logic hit;

  assign pready = 1'b1;
  assign hit = (paddr[2] == REG_PARAM_ONLY_CODE) && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      param_only_code <= PARAM_ONLY_CODE_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      param_only_code <= pwdata[7:0];
    end
  end

  assign prdata = hit ? {{(APB_DATA_W-8){1'b0}}, param_only_code} : '0;

endmodule

// ===== src/ltp_parser.sv =====
// ----------------------------------------------------------------------------
// ltp_parser
// Input register, TLV parse state and result register.
// ----------------------------------------------------------------------------
module ltp_parser
  import ltp_pkg::*;
#(
  parameter int NUM_PARAMS = NUM_PARAMS_DEFAULT
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] param_only_code,
  ltp_cmd_if.sink    cmd,
  ltp_wr_if.source   wr
);

  localparam logic [8:0] ID_LIMIT = 9'(NUM_PARAMS);

  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        stage_first;
  logic        stage_last;
  logic        advance;
  logic        process;

  ltp_phase_t  parse_phase, parse_phase_next;
  logic [7:0]  current_pattern, current_pattern_next;
  logic [3:0]  pending_param, pending_param_next;
  logic [7:0]  high_value_byte, high_value_byte_next;
  logic        parse_stopped, parse_stopped_next;

  logic        emit;
  ltp_result_t result_next;
  logic        out_valid;
  ltp_result_t out_data;

  assign advance = !out_valid || wr.ready;
  assign process = stage_valid && advance;
  assign cmd.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      stage_byte  <= cmd.cmd_byte;
      stage_first <= cmd.first_byte;
      stage_last  <= cmd.last_byte;
    end
  end

  always_comb begin
    parse_phase_next     = parse_phase;
    current_pattern_next = current_pattern;
    pending_param_next   = pending_param;
    high_value_byte_next = high_value_byte;
    parse_stopped_next   = parse_stopped;
    emit                 = 1'b0;
    result_next          = '0;

    if (stage_first) begin
      parse_stopped_next = 1'b0;
      parse_phase_next   = PH_ID;
      if (stage_byte != param_only_code) begin
        emit                        = 1'b1;
        result_next.write_kind      = WRITE_PATTERN;
        result_next.pattern_code    = stage_byte;
        result_next.pattern_changed = (stage_byte != current_pattern);
        current_pattern_next        = stage_byte;
      end
    end else if (!parse_stopped) begin
      unique case (parse_phase)
        PH_IDLE: begin
        end
        PH_ID: begin
          if ({1'b0, stage_byte} < ID_LIMIT) begin
            pending_param_next = stage_byte[3:0];
            parse_phase_next   = PH_VAL;
          end else begin
            parse_stopped_next = 1'b1;
          end
        end
        PH_VAL: begin
          if (is_pair(pending_param)) begin
            high_value_byte_next = stage_byte;
            parse_phase_next     = PH_LOW;
          end else begin
            emit                    = 1'b1;
            result_next.write_kind  = WRITE_PARAM;
            result_next.param_index = pending_param;
            result_next.param_value = {8'h00, stage_byte};
            parse_phase_next        = PH_ID;
          end
        end
        PH_LOW: begin
          emit                    = 1'b1;
          result_next.write_kind  = WRITE_PARAM;
          result_next.param_index = pending_param;
          result_next.param_value = {high_value_byte, stage_byte};
          parse_phase_next        = PH_ID;
        end
        default: begin
          parse_phase_next = PH_IDLE;
        end
      endcase
    end

    if (stage_last) begin
      parse_phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_IDLE;
      current_pattern <= 8'h00;
      pending_param   <= 4'h0;
      high_value_byte <= 8'h00;
      parse_stopped   <= 1'b0;
    end else if (process) begin
      parse_phase     <= parse_phase_next;
      current_pattern <= current_pattern_next;
      pending_param   <= pending_param_next;
      high_value_byte <= high_value_byte_next;
      parse_stopped   <= parse_stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= process && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      out_data <= result_next;
    end
  end

  assign wr.valid           = out_valid;
  assign wr.write_kind      = out_data.write_kind;
  assign wr.pattern_code    = out_data.pattern_code;
  assign wr.pattern_changed = out_data.pattern_changed;
  assign wr.param_index     = out_data.param_index;
  assign wr.param_value     = out_data.param_value;

endmodule

// ===== src/led_command_tlv_parser.sv =====
// ----------------------------------------------------------------------------
// led_command_tlv_parser
// Streaming parser for light commands in type-length-value form.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake      Payload
//  cmd       in    valid/ready    cmd_byte, first_byte, last_byte
//  wr        out   valid/ready    write_kind, pattern_code, pattern_changed,
//                                 param_index, param_value
//  apb       cfg   psel/penable   param_only_code at byte address 0
//
//  One byte is accepted per cycle while wr does not stall; a request is presented
//  after its byte has passed the input register and then the result register.
//  Reset is synchronous and returns the parser to waiting for a pattern byte.
//  When wr stalls, the input register holds one more byte and cmd then
//  drops ready until the result is taken.
// ----------------------------------------------------------------------------
module led_command_tlv_parser
  import ltp_pkg::*;
#(
  parameter int NUM_PARAMS = NUM_PARAMS_DEFAULT
)
(
  input  logic                  clk,
  input  logic                  rst,
  ltp_cmd_if.sink               cmd,
  ltp_wr_if.source              wr,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [7:0] param_only_code;

  ltp_apb_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .param_only_code (param_only_code)
  );

  ltp_parser #(
    .NUM_PARAMS (NUM_PARAMS)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .param_only_code (param_only_code),
    .cmd             (cmd),
    .wr              (wr)
  );

endmodule
